// ===== design/stf_pkg.sv =====
// Shared types and constants for the scancode-to-ASCII keyboard buffer.
// Holds the beat payload structs, command codes and the set-1 scancode ROM.
// Depends on nothing.
package stf_pkg;

    localparam int SCAN_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int LEVEL_W = 4;

    // Command codes carried in the input beat.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Bit of the scancode that marks a key release.
    localparam int BREAK_BIT = 7;

    // Control characters that appear in the ROM.
    localparam logic [CHAR_W-1:0] CHR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHR_BS    = 7'h08;
    localparam logic [CHAR_W-1:0] CHR_TAB   = 7'h09;
    localparam logic [CHAR_W-1:0] CHR_CR    = 7'h0d;
    localparam logic [CHAR_W-1:0] CHR_ESC   = 7'h1b;
    localparam logic [CHAR_W-1:0] CHR_QUOTE = 7'h27;

    typedef struct packed {
        logic              cmd;
        logic [SCAN_W-1:0] scan_code;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic [LEVEL_W-1:0] level;
    } out_beat_t;

    // Set-1 make code to ASCII; zero means the key has no character.
    function automatic logic [CHAR_W-1:0] key_rom(input logic [SCAN_W-2:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            7'h01: c = CHR_ESC;
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0a: c = 7'h39;
            7'h0b: c = 7'h30;
            7'h0c: c = 7'h2d;
            7'h0d: c = 7'h2b;
            7'h0e: c = CHR_BS;
            7'h0f: c = CHR_TAB;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6f;
            7'h19: c = 7'h70;
            7'h1a: c = 7'h5b;
            7'h1b: c = 7'h5d;
            7'h1c: c = CHR_CR;
            7'h1e: c = 7'h61;
            7'h1f: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6a;
            7'h25: c = 7'h6b;
            7'h26: c = 7'h6c;
            7'h27: c = 7'h3b;
            7'h28: c = 7'h3a;
            7'h29: c = 7'h60;
            7'h2b: c = CHR_QUOTE;
            7'h2c: c = 7'h7a;
            7'h2d: c = 7'h78;
            7'h2e: c = 7'h63;
            7'h2f: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6e;
            7'h32: c = 7'h6d;
            7'h33: c = 7'h2c;
            7'h34: c = 7'h2e;
            7'h35: c = 7'h2f;
            7'h36: c = 7'h3f;
            7'h37: c = 7'h2a;
            7'h39: c = 7'h20;
            7'h47: c = 7'h37;
            7'h48: c = 7'h38;
            7'h49: c = 7'h39;
            7'h4a: c = 7'h2d;
            7'h4b: c = 7'h34;
            7'h4c: c = 7'h35;
            7'h4d: c = 7'h36;
            7'h4e: c = 7'h2b;
            7'h4f: c = 7'h31;
            7'h50: c = 7'h32;
            7'h51: c = 7'h33;
            7'h52: c = 7'h30;
            7'h53: c = 7'h2e;
            7'h56: c = 7'h5a;
            default: c = CHR_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== design/scancode_to_ascii_fifo_top.sv =====
// Top level of the keyboard buffer: scancode ROM lookup feeding a ring FIFO.
// Depends on stf_pkg for the beat structs, command codes and the ROM.
//
// Usage:
// The input channel (s_valid, s_ready, s_payload) takes one command beat per
// cycle while s_ready is high. A push beat carries a set-1 scancode; release
// codes and keys without a character are ignored, and any other key appends its
// ASCII character. When the buffer would fill to BUFFER_DEPTH characters the
// oldest one is dropped, so at most BUFFER_DEPTH-1 characters are held. A push
// never produces an output beat.
// A pop beat produces one output beat (m_valid, m_ready, m_payload) carrying
// the oldest character (zero if the buffer was empty) and the count left.
// The output beat is registered and becomes valid in the cycle after the pop is accepted.
// Throughput: one beat per cycle while output beats are taken, set by the single
// registered read port of the character store and the one-deep output register.
// When the receiver stalls, the pending output beat holds and s_ready drops
// until it is taken; taking it frees the slot in the same cycle.
// Reset clears the pointers, the fill count and the output valid; the store
// contents are left as they are and need no clearing pass.
module scancode_to_ascii_fifo_top #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stf_pkg::in_beat_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output stf_pkg::out_beat_t  m_payload
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [PTR_W-1:0] FULL_CNT  = PTR_W'(BUFFER_DEPTH - 1);

    logic [stf_pkg::CHAR_W-1:0] store_mem [BUFFER_DEPTH];

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] count_reg,  count_next;
    logic             m_valid_reg, m_valid_next;
    logic             empty_reg;
    logic [stf_pkg::LEVEL_W-1:0] level_reg;
    logic [stf_pkg::CHAR_W-1:0]  rd_data_reg;

    logic                       accept;
    logic                       is_pop;
    logic [stf_pkg::CHAR_W-1:0] lookup_char;
    logic                       do_write;
    logic                       do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    // Input handshake: accept whenever the output slot is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_pop  = (s_payload.cmd == stf_pkg::CMD_POP);

    // Scancode lookup; release codes and unmapped keys write nothing.
    assign lookup_char = stf_pkg::key_rom(s_payload.scan_code[stf_pkg::SCAN_W-2:0]);
    assign do_write    = accept && !is_pop
                         && !s_payload.scan_code[stf_pkg::BREAK_BIT]
                         && (lookup_char != stf_pkg::CHR_NONE);
    assign do_pop      = accept && is_pop && (count_reg != '0);

    // Pointer and fill count update for one accepted beat.
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_write) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            if (count_reg == FULL_CNT) begin
                // Buffer would fill completely: the oldest character is dropped.
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end else begin
                count_next = count_reg + PTR_W'(1);
            end
        end else if (do_pop) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            count_next  = count_reg - PTR_W'(1);
        end
    end

    // Output valid: set by a pop, cleared once the beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (accept && is_pop) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Character store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (do_write) begin
            store_mem[wr_ptr_reg] <= lookup_char;
        end
        if (accept && is_pop) begin
            rd_data_reg <= store_mem[rd_ptr_reg];
        end
    end

    // Result payload registers, loaded on every accepted pop.
    always_ff @(posedge aclk) begin
        if (accept && is_pop) begin
            empty_reg <= (count_reg == '0);
            level_reg <= stf_pkg::LEVEL_W'(count_next);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_payload.character = empty_reg ? stf_pkg::CHR_NONE : rd_data_reg;
    assign m_payload.level     = level_reg;

endmodule
